// ----- rtl/core/nwr_pkg.sv -----
package nwr_pkg;

  localparam int unsigned Slots     = 8;
  localparam int unsigned NodeCount = 8;   // nodes in use, 2..8; higher slots are absent
  localparam int unsigned Stages    = 5;
  localparam int unsigned WeightW   = 16;
  localparam int unsigned OutW      = 19;
  localparam int unsigned CodeW     = 2;
  localparam int unsigned CodesW    = Slots * CodeW;
  localparam int unsigned CntW      = 4;
  localparam int unsigned RecipFrac = 16;
  localparam int unsigned RecipW    = RecipFrac + 1;
  localparam int unsigned ProdW     = WeightW + RecipW;
  localparam int unsigned QcW       = WeightW + CntW;
  localparam int unsigned RecipOne  = 1 << RecipFrac;

  typedef logic [WeightW-1:0] weight_t;
  typedef logic [OutW-1:0]    wout_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [RecipW-1:0]  recip_t;
  typedef logic [Slots-1:0]   mask_t;

  localparam logic [CodeW-1:0] CodeNone    = 2'd0;
  localparam logic [CodeW-1:0] CodeConn    = 2'd1;
  localparam logic [CodeW-1:0] CodeContact = 2'd2;
  localparam logic [CodeW-1:0] CodeSpare   = 2'd3;
  localparam logic             ModeContact = 1'b1;

  typedef struct packed {
    mask_t  act;
    mask_t  redist;
    cnt_t   cnt;
    recip_t recip;
  } cls_t;

  typedef struct packed {
    logic ld_mul;
    logic ld_share;
  } lane_ctl_t;

  typedef struct packed {
    logic ld_sum;
    logic ld_out;
  } merge_ctl_t;

  // floor(2^16 / c); the quotient estimate is low by at most one
  function automatic recip_t recip_of(cnt_t c);
    recip_t r;
    case (c)
      cnt_t'(1): r = recip_t'(RecipOne / 1);
      cnt_t'(2): r = recip_t'(RecipOne / 2);
      cnt_t'(3): r = recip_t'(RecipOne / 3);
      cnt_t'(4): r = recip_t'(RecipOne / 4);
      cnt_t'(5): r = recip_t'(RecipOne / 5);
      cnt_t'(6): r = recip_t'(RecipOne / 6);
      cnt_t'(7): r = recip_t'(RecipOne / 7);
      cnt_t'(8): r = recip_t'(RecipOne / 8);
      default:   r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/nwr_in_if.sv -----
interface nwr_in_if import nwr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CodesW-1:0] node_codes;
  weight_t           weight_in_0;
  weight_t           weight_in_1;
  weight_t           weight_in_2;
  weight_t           weight_in_3;
  weight_t           weight_in_4;
  weight_t           weight_in_5;
  weight_t           weight_in_6;
  weight_t           weight_in_7;

  modport source (
    output valid, mode, node_codes,
    output weight_in_0, weight_in_1, weight_in_2, weight_in_3,
    output weight_in_4, weight_in_5, weight_in_6, weight_in_7,
    input  ready
  );

  modport sink (
    input  valid, mode, node_codes,
    input  weight_in_0, weight_in_1, weight_in_2, weight_in_3,
    input  weight_in_4, weight_in_5, weight_in_6, weight_in_7,
    output ready
  );
endinterface

// ----- rtl/core/nwr_out_if.sv -----
interface nwr_out_if import nwr_pkg::*; ();
  logic  valid;
  logic  ready;
  wout_t weight_out_0;
  wout_t weight_out_1;
  wout_t weight_out_2;
  wout_t weight_out_3;
  wout_t weight_out_4;
  wout_t weight_out_5;
  wout_t weight_out_6;
  wout_t weight_out_7;
  cnt_t  active_count;

  modport source (
    output valid,
    output weight_out_0, weight_out_1, weight_out_2, weight_out_3,
    output weight_out_4, weight_out_5, weight_out_6, weight_out_7,
    output active_count,
    input  ready
  );

  modport sink (
    input  valid,
    input  weight_out_0, weight_out_1, weight_out_2, weight_out_3,
    input  weight_out_4, weight_out_5, weight_out_6, weight_out_7,
    input  active_count,
    output ready
  );
endinterface

// ----- rtl/core/node_weight_redistribution_core.sv -----
// Channel   Dir  Payload
// in_i      in   mode, node_codes, weight_in_0..7
// out_o     out  weight_out_0..7, active_count
//
// One transaction per cycle unless out_o stalls; the steps are classify, reciprocal multiply,
// remainder fix-up, share sum and output add, one register per step.
// Reset clears only the stage valid bits.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up; in_i drops ready only once all five stages are full and out_o
// stalls.
module node_weight_redistribution_core import nwr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  nwr_in_if.sink    in_i,
  nwr_out_if.source out_o
);

  logic [Stages-1:0] v_d, v_q, en;

  weight_t    w_in [Slots];
  cls_t       cls;
  weight_t    w_cls [Slots];
  weight_t    share [Slots];
  weight_t    w_lane [Slots];
  mask_t      act_lane;
  cnt_t       cnt1_q, cnt2_q;
  wout_t      wout [Slots];
  lane_ctl_t  lane_ctl;
  merge_ctl_t merge_ctl;

  always_comb begin
    logic nxt;
    nxt = out_o.ready;
    for (int s = Stages - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || nxt;
      nxt   = en[s];
    end
  end

  always_comb begin
    v_d[0] = en[0] ? in_i.valid : v_q[0];
    for (int s = 1; s < Stages; s++) begin
      v_d[s] = en[s] ? v_q[s-1] : v_q[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_i.ready = en[0];

  assign w_in[0] = in_i.weight_in_0;
  assign w_in[1] = in_i.weight_in_1;
  assign w_in[2] = in_i.weight_in_2;
  assign w_in[3] = in_i.weight_in_3;
  assign w_in[4] = in_i.weight_in_4;
  assign w_in[5] = in_i.weight_in_5;
  assign w_in[6] = in_i.weight_in_6;
  assign w_in[7] = in_i.weight_in_7;

  nwr_classify u_classify (
    .clk_i   (clk_i),
    .en_i    (en[0]),
    .mode_i  (in_i.mode),
    .codes_i (in_i.node_codes),
    .w_i     (w_in),
    .cls_o   (cls),
    .w_o     (w_cls)
  );

  assign lane_ctl.ld_mul   = en[1];
  assign lane_ctl.ld_share = en[2];

  for (genvar k = 0; k < Slots; k++) begin : g_lane
    nwr_lane u_lane (
      .clk_i    (clk_i),
      .ctl_i    (lane_ctl),
      .w_i      (w_cls[k]),
      .act_i    (cls.act[k]),
      .redist_i (cls.redist[k]),
      .cnt_i    (cls.cnt),
      .recip_i  (cls.recip),
      .share_o  (share[k]),
      .w_o      (w_lane[k]),
      .act_o    (act_lane[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      cnt1_q <= cls.cnt;
    end
    if (en[2]) begin
      cnt2_q <= cnt1_q;
    end
  end

  assign merge_ctl.ld_sum = en[3];
  assign merge_ctl.ld_out = en[4];

  nwr_merge u_merge (
    .clk_i   (clk_i),
    .ctl_i   (merge_ctl),
    .share_i (share),
    .w_i     (w_lane),
    .act_i   (act_lane),
    .cnt_i   (cnt2_q),
    .wout_o  (wout),
    .cnt_o   (out_o.active_count)
  );

  assign out_o.valid        = v_q[Stages-1];
  assign out_o.weight_out_0 = wout[0];
  assign out_o.weight_out_1 = wout[1];
  assign out_o.weight_out_2 = wout[2];
  assign out_o.weight_out_3 = wout[3];
  assign out_o.weight_out_4 = wout[4];
  assign out_o.weight_out_5 = wout[5];
  assign out_o.weight_out_6 = wout[6];
  assign out_o.weight_out_7 = wout[7];

endmodule

// ----- rtl/core/nwr_classify.sv -----
module nwr_classify import nwr_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic              mode_i,
  input  logic [CodesW-1:0] codes_i,
  input  weight_t           w_i [Slots],
  output cls_t              cls_o,
  output weight_t           w_o [Slots]
);

  cls_t    cls_d, cls_q;
  weight_t w_q [Slots];

  always_comb begin
    logic [CodeW-1:0] code;
    logic             on;
    cls_d = '0;
    for (int k = 0; k < Slots; k++) begin
      code = codes_i[k*CodeW +: CodeW];
      on   = (mode_i == ModeContact) ? (code != CodeNone) : (code == CodeConn);
      cls_d.act[k]    = (k < NodeCount) && on;
      cls_d.redist[k] = (k < NodeCount) && !on;
      cls_d.cnt       = cls_d.cnt + cnt_t'(cls_d.act[k]);
    end
    cls_d.recip = recip_of(cls_d.cnt);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cls_q <= cls_d;
      w_q   <= w_i;
    end
  end

  assign cls_o = cls_q;
  assign w_o   = w_q;

endmodule

// ----- rtl/core/nwr_lane.sv -----
module nwr_lane import nwr_pkg::*; (
  input  logic      clk_i,
  input  lane_ctl_t ctl_i,
  input  weight_t   w_i,
  input  logic      act_i,
  input  logic      redist_i,
  input  cnt_t      cnt_i,
  input  recip_t    recip_i,
  output weight_t   share_o,
  output weight_t   w_o,
  output logic      act_o
);

  logic [ProdW-1:0] prod;
  weight_t          q0_d, q0_q, wa_q;
  cnt_t             cnt_q;
  logic             act_a_q, red_a_q;

  logic [QcW-1:0]   qc, rem;
  logic             bump;
  weight_t          share_d, share_q, wb_q;
  logic             act_b_q;

  // quotient estimate by reciprocal multiply
  assign prod = ProdW'(w_i) * ProdW'(recip_i);
  assign q0_d = prod[RecipFrac +: WeightW];

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_mul) begin
      q0_q    <= q0_d;
      wa_q    <= w_i;
      cnt_q   <= cnt_i;
      act_a_q <= act_i;
      red_a_q <= redist_i;
    end
  end

  // remainder check fixes the estimate up by one
  assign qc      = QcW'(q0_q) * QcW'(cnt_q);
  assign rem     = QcW'(wa_q) - qc;
  assign bump    = rem >= QcW'(cnt_q);
  assign share_d = red_a_q ? (q0_q + WeightW'(bump)) : '0;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_share) begin
      share_q <= share_d;
      wb_q    <= wa_q;
      act_b_q <= act_a_q;
    end
  end

  assign share_o = share_q;
  assign w_o     = wb_q;
  assign act_o   = act_b_q;

endmodule

// ----- rtl/core/nwr_merge.sv -----
module nwr_merge import nwr_pkg::*; (
  input  logic       clk_i,
  input  merge_ctl_t ctl_i,
  input  weight_t    share_i [Slots],
  input  weight_t    w_i [Slots],
  input  mask_t      act_i,
  input  cnt_t       cnt_i,
  output wout_t      wout_o [Slots],
  output cnt_t       cnt_o
);

  wout_t   total_d, total_q;
  weight_t w_q [Slots];
  mask_t   act_q;
  cnt_t    cnt_q;
  wout_t   out_d [Slots];
  wout_t   out_q [Slots];
  cnt_t    cnt_out_q;

  always_comb begin
    total_d = '0;
    for (int k = 0; k < Slots; k++) begin
      total_d = total_d + OutW'(share_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_sum) begin
      total_q <= total_d;
      w_q     <= w_i;
      act_q   <= act_i;
      cnt_q   <= cnt_i;
    end
  end

  always_comb begin
    for (int k = 0; k < Slots; k++) begin
      out_d[k] = act_q[k] ? (OutW'(w_q[k]) + total_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_out) begin
      out_q     <= out_d;
      cnt_out_q <= cnt_q;
    end
  end

  assign wout_o = out_q;
  assign cnt_o  = cnt_out_q;

endmodule

// ----- tb/node_weight_redistribution_core_test.sv -----
module node_weight_redistribution_core_test;
  import nwr_pkg::*;

  localparam int unsigned RandomSets = 900;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned MaxPrinted = 30;

  typedef struct packed {
    logic              mode;
    logic [CodesW-1:0] codes;
    weight_t [Slots-1:0] w;
  } weight_set_t;

  typedef struct packed {
    wout_t [Slots-1:0] w;
    cnt_t              cnt;
  } redist_t;

  typedef enum logic [1:0] {RxOpen, RxToggle, RxSparse, RxCoin} rx_pattern_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  nwr_in_if  in_if ();
  nwr_out_if out_if ();

  node_weight_redistribution_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  weight_set_t weight_sets_q[$];
  redist_t     expected_weights_q[$];
  weight_set_t next_set;
  weight_set_t seen_set;
  redist_t     got_weights;
  redist_t     want_weights;

  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned rx_left;
  rx_pattern_e rx_pattern;
  int unsigned n_total;
  int unsigned n_accepted = 0;
  int unsigned n_checked = 0;
  int unsigned n_empty = 0;
  int unsigned n_contact = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  function automatic redist_t redistribute(weight_set_t s);
    redist_t            r;
    mask_t              act;
    int unsigned        cnt;
    int unsigned        share_sum;
    logic [CodeW-1:0]   code;
    r = '0;
    act = '0;
    cnt = 0;
    share_sum = 0;
    for (int k = 0; k < Slots; k++) begin
      code = s.codes[CodeW*k +: CodeW];
      act[k] = (k < NodeCount) &&
               ((s.mode == ModeContact) ? (code != CodeNone) : (code == CodeConn));
      if (act[k]) cnt++;
    end
    if (cnt != 0) begin
      for (int k = 0; k < NodeCount; k++)
        if (!act[k]) share_sum += s.w[k] / cnt;
      for (int k = 0; k < Slots; k++)
        if (act[k]) r.w[k] = wout_t'(s.w[k] + share_sum);
    end
    r.cnt = cnt_t'(cnt);
    return r;
  endfunction

  function automatic weight_set_t flat_set(logic mode, logic [CodesW-1:0] codes, weight_t w);
    weight_set_t s;
    s.mode = mode;
    s.codes = codes;
    for (int k = 0; k < Slots; k++) s.w[k] = w;
    return s;
  endfunction

  function automatic weight_t random_weight();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return weight_t'($urandom_range(0, 32768));
    if (pick < 75) return weight_t'($urandom_range(0, 65535));
    if (pick < 85) begin
      case ($urandom_range(0, 3))
        0: return weight_t'(0);
        1: return weight_t'(1);
        2: return weight_t'(32767);
        default: return weight_t'(32768);
      endcase
    end
    return weight_t'($urandom_range(0, 8192));
  endfunction

  task automatic report(string msg);
    errors++;
    if (errors <= MaxPrinted) $display("[%0t] mismatch %0d: %s", $time, errors, msg);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.mode        <= 1'b0;
      in_if.node_codes  <= '0;
      in_if.weight_in_0 <= '0;
      in_if.weight_in_1 <= '0;
      in_if.weight_in_2 <= '0;
      in_if.weight_in_3 <= '0;
      in_if.weight_in_4 <= '0;
      in_if.weight_in_5 <= '0;
      in_if.weight_in_6 <= '0;
      in_if.weight_in_7 <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        in_if.valid <= 1'b0;
        gap_left    <= gap_left - 1;
      end else if (weight_sets_q.size() != 0) begin
        next_set = weight_sets_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.mode        <= next_set.mode;
        in_if.node_codes  <= next_set.codes;
        in_if.weight_in_0 <= next_set.w[0];
        in_if.weight_in_1 <= next_set.w[1];
        in_if.weight_in_2 <= next_set.w[2];
        in_if.weight_in_3 <= next_set.w[3];
        in_if.weight_in_4 <= next_set.w[4];
        in_if.weight_in_5 <= next_set.w[5];
        in_if.weight_in_6 <= next_set.w[6];
        in_if.weight_in_7 <= next_set.w[7];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver: switches between stall patterns after a random hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_left      <= 0;
      rx_pattern   <= RxOpen;
    end else begin
      if (rx_left == 0) begin
        rx_pattern <= rx_pattern_e'($urandom_range(0, 3));
        rx_left    <= $urandom_range(8, 64);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_pattern)
        RxOpen:   out_if.ready <= 1'b1;
        RxToggle: out_if.ready <= !out_if.ready;
        RxSparse: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:  out_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        seen_set.mode  = in_if.mode;
        seen_set.codes = in_if.node_codes;
        seen_set.w[0]  = in_if.weight_in_0;
        seen_set.w[1]  = in_if.weight_in_1;
        seen_set.w[2]  = in_if.weight_in_2;
        seen_set.w[3]  = in_if.weight_in_3;
        seen_set.w[4]  = in_if.weight_in_4;
        seen_set.w[5]  = in_if.weight_in_5;
        seen_set.w[6]  = in_if.weight_in_6;
        seen_set.w[7]  = in_if.weight_in_7;
        expected_weights_q.push_back(redistribute(seen_set));
        n_accepted++;
        if (seen_set.mode == ModeContact) n_contact++;
      end
      if (out_if.valid && out_if.ready) begin
        got_weights.w[0] = out_if.weight_out_0;
        got_weights.w[1] = out_if.weight_out_1;
        got_weights.w[2] = out_if.weight_out_2;
        got_weights.w[3] = out_if.weight_out_3;
        got_weights.w[4] = out_if.weight_out_4;
        got_weights.w[5] = out_if.weight_out_5;
        got_weights.w[6] = out_if.weight_out_6;
        got_weights.w[7] = out_if.weight_out_7;
        got_weights.cnt  = out_if.active_count;
        if (expected_weights_q.size() == 0) begin
          report("result with no transaction outstanding");
        end else begin
          want_weights = expected_weights_q.pop_front();
          for (int k = 0; k < Slots; k++)
            if (got_weights.w[k] !== want_weights.w[k])
              report($sformatf("result %0d weight_out_%0d = %0d, want %0d",
                               n_checked, k, got_weights.w[k], want_weights.w[k]));
          if (got_weights.cnt !== want_weights.cnt)
            report($sformatf("result %0d active_count = %0d, want %0d",
                             n_checked, got_weights.cnt, want_weights.cnt));
          if (want_weights.cnt == 0) n_empty++;
        end
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d of %0d transactions accepted, %0d results",
               cycles, n_accepted, n_total, n_checked);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    weight_set_t s;
    int unsigned bias;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.mode        = 1'b0;
    in_if.node_codes  = '0;
    in_if.weight_in_0 = '0;
    in_if.weight_in_1 = '0;
    in_if.weight_in_2 = '0;
    in_if.weight_in_3 = '0;
    in_if.weight_in_4 = '0;
    in_if.weight_in_5 = '0;
    in_if.weight_in_6 = '0;
    in_if.weight_in_7 = '0;
    out_if.ready      = 1'b0;

    // no active node
    weight_sets_q.push_back(flat_set(1'b0, 16'h0000, 16'hFFFF));
    weight_sets_q.push_back(flat_set(1'b1, 16'h0000, 16'd32768));
    // all nodes active, nothing to move; the last set has no active node
    weight_sets_q.push_back(flat_set(1'b0, 16'h5555, 16'd32768));
    weight_sets_q.push_back(flat_set(1'b1, 16'hAAAA, 16'd4096));
    weight_sets_q.push_back(flat_set(1'b0, 16'hAAAA, 16'd4096));
    // code 3 in both modes
    weight_sets_q.push_back(flat_set(1'b0, 16'hFFFF, 16'd1234));
    weight_sets_q.push_back(flat_set(1'b1, 16'hFFFF, 16'hFFFF));
    // single active node gathers everything, largest output; then mixed codes in both modes
    weight_sets_q.push_back(flat_set(1'b0, 16'h0001, 16'hFFFF));
    weight_sets_q.push_back(flat_set(1'b1, 16'h8000, 16'hFFFF));
    weight_sets_q.push_back(flat_set(1'b0, 16'hE4E4, 16'd5));
    weight_sets_q.push_back(flat_set(1'b1, 16'hE4E4, 16'd5));
    // shares truncate (to zero in the first set), then other corner sets
    weight_sets_q.push_back(flat_set(1'b0, 16'h5554, 16'd6));
    weight_sets_q.push_back(flat_set(1'b1, 16'h0024, 16'd3));
    weight_sets_q.push_back(flat_set(1'b0, 16'h5555, 16'hAAAA));
    weight_sets_q.push_back(flat_set(1'b1, 16'hAAAA, 16'h5555));
    weight_sets_q.push_back(flat_set(1'b1, 16'h1144, 16'd0));
    s = flat_set(1'b1, 16'h9C63, 16'd4096);
    s.w[0] = 16'd0;
    s.w[1] = 16'd1;
    s.w[2] = 16'd32767;
    s.w[3] = 16'd32768;
    s.w[5] = 16'hFFFF;
    weight_sets_q.push_back(s);
    s.mode = 1'b0;
    weight_sets_q.push_back(s);

    for (int i = 0; i < RandomSets; i++) begin
      s.mode = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        s.codes = CodesW'($urandom_range(0, 65535));
      end else begin
        bias = $urandom_range(0, 10);
        for (int k = 0; k < Slots; k++) begin
          if ($urandom_range(0, 9) < bias)
            s.codes[CodeW*k +: CodeW] = $urandom_range(0, 3) == 0 ? CodeContact : CodeConn;
          else
            s.codes[CodeW*k +: CodeW] = $urandom_range(0, 3) == 0 ? CodeSpare : CodeNone;
        end
      end
      for (int k = 0; k < Slots; k++) s.w[k] = random_weight();
      weight_sets_q.push_back(s);
    end
    n_total = weight_sets_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted != n_total) @(negedge clk_i);
    while (expected_weights_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("%0d weight sets redistributed and checked in %0d cycles", n_checked, cycles);
    $display("%0d in contact mode, %0d with no active node, %0d field mismatches",
             n_contact, n_empty, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/nwr_pkg.sv
rtl/core/nwr_in_if.sv
rtl/core/nwr_out_if.sv
rtl/core/nwr_classify.sv
rtl/core/nwr_lane.sv
rtl/core/nwr_merge.sv
rtl/core/node_weight_redistribution_core.sv
tb/node_weight_redistribution_core_test.sv
